// ----- hw/rtl/rsr_pkg.sv -----
package rsr_pkg;

  localparam int unsigned MAX_RECORDS = 32;
  localparam int unsigned NAME_CHARS  = 10;
  localparam int unsigned CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int unsigned TOTAL_W     = 24;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_FEE    = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  typedef enum logic {ST_LOAD, ST_DRAIN} state_e;

  typedef struct packed {
    logic [15:0]        name_high;
    logic [63:0]        name_low;
    logic [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]   id;
  } rec_t;

  typedef struct packed {
    logic ins;    // place the broadcast record into the chain
    logic shift;  // move every record one cell toward the head
  } cell_ctrl_t;

  // Cut the name at its first zero byte and at NAME_CHARS characters.
  function automatic logic [79:0] norm_name(input logic [79:0] raw);
    logic [79:0] res;
    logic        ended;
    res   = raw;
    ended = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (i >= NAME_CHARS || raw[79-8*i -: 8] == 8'd0) ended = 1'b1;
      if (ended) res[79-8*i -: 8] = 8'd0;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/rsr_cell.sv -----
module rsr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsr_pkg::cell_ctrl_t ctrl_i,
  input  rsr_pkg::rec_t     new_i,
  input  rsr_pkg::rec_t     left_i,
  input  logic              left_valid_i,
  input  logic              left_before_i,
  input  rsr_pkg::rec_t     right_i,
  input  logic              right_valid_i,
  output rsr_pkg::rec_t     rec_o,
  output logic              valid_o,
  output logic              before_o
);

  rsr_pkg::rec_t rec_q, rec_d;
  logic          valid_q, valid_d;

  // New record sorts ahead of this one: this cell is empty, higher total, or equal total and lower name.
  // Ids only grow, so an equal key keeps the stored record first.
  always_comb begin
    before_o = !valid_q
            || (new_i.total > rec_q.total)
            || ((new_i.total == rec_q.total)
                && ({new_i.name_high, new_i.name_low} < {rec_q.name_high, rec_q.name_low}));
  end

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      rec_d   = right_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.ins && before_o) begin
      if (left_before_i) begin
        rec_d   = left_i;
        valid_d = left_valid_i;
      end else begin
        rec_d   = new_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

// ----- hw/rtl/record_sort_and_rank_unit.sv -----
// The open record enters the cell chain when the next start or finish beat arrives.
// Finish: the open record is inserted, then one result per cycle is drained from the head
// cell (max(n,1) results) into the output register, while that register is free.
// Input stalls while draining. Reset (async, active low) empties the chain,
// clears the count and the overflow flag; no clearing pass.
module record_sort_and_rank_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] name_high_i,
  input  logic [63:0] name_low_i,
  input  logic [15:0] fee_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  rank_o,
  output logic [5:0]  record_id_o,
  output logic [15:0] out_name_high_o,
  output logic [63:0] out_name_low_o,
  output logic [23:0] total_out_o,
  output logic        has_record_o,
  output logic        overflowed_o,
  output logic        last_o
);

  localparam int unsigned N = rsr_pkg::MAX_RECORDS;
  localparam int unsigned CW = rsr_pkg::CNT_W;
  localparam int unsigned TW = rsr_pkg::TOTAL_W;

  rsr_pkg::state_e state_q, state_d;
  rsr_pkg::rec_t   hold_q, hold_d;
  logic            open_q, open_d;
  logic [CW-1:0]   count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   rank_q, rank_d;
  logic [TW-1:0]   prev_total_q, prev_total_d;
  logic            out_valid_q, out_valid_d;
  logic [5:0]      o_rank_q, o_rank_d;
  rsr_pkg::rec_t   o_rec_q, o_rec_d;
  logic            o_has_q, o_has_d, o_ovf_q, o_ovf_d, o_last_q, o_last_d;

  rsr_pkg::cell_ctrl_t ctrl;
  rsr_pkg::rec_t       cell_rec [N];
  logic [N-1:0]        cell_valid, cell_before;

  logic          in_acc, out_free, drain_step;
  logic [TW:0]   fee_sum;
  logic [79:0]   name_norm;
  logic [CW-1:0] cur_rank;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign drain_step = (state_q == rsr_pkg::ST_DRAIN) && out_free;
  assign fee_sum    = {1'b0, hold_q.total} + {{(TW-15){1'b0}}, fee_i};
  assign name_norm  = rsr_pkg::norm_name({name_high_i, name_low_i});
  assign cur_rank   = (idx_q == '0 || cell_rec[0].total != prev_total_q)
                    ? idx_q + CW'(1) : rank_q;

  // Cell chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    rsr_pkg::rec_t lrec, rrec;
    logic          lval, lbef, rval;
    if (g == 0) begin : g_head
      assign lrec = hold_q;
      assign lval = 1'b0;
      assign lbef = 1'b0;
    end else begin : g_body
      assign lrec = cell_rec[g-1];
      assign lval = cell_valid[g-1];
      assign lbef = cell_before[g-1];
    end
    if (g == N - 1) begin : g_tail
      assign rrec = hold_q;
      assign rval = 1'b0;
    end else begin : g_inner
      assign rrec = cell_rec[g+1];
      assign rval = cell_valid[g+1];
    end
    rsr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (hold_q),
      .left_i       (lrec),
      .left_valid_i (lval),
      .left_before_i(lbef),
      .right_i      (rrec),
      .right_valid_i(rval),
      .rec_o        (cell_rec[g]),
      .valid_o      (cell_valid[g]),
      .before_o     (cell_before[g])
    );
  end

  // Control and result staging
  always_comb begin
    state_d      = state_q;
    hold_d       = hold_q;
    open_d       = open_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    idx_d        = idx_q;
    rank_d       = rank_q;
    prev_total_d = prev_total_q;
    out_valid_d  = out_valid_q && out_stall_i;
    o_rank_d     = o_rank_q;
    o_rec_d      = o_rec_q;
    o_has_d      = o_has_q;
    o_ovf_d      = o_ovf_q;
    o_last_d     = o_last_q;
    ctrl         = '0;
    in_stall_o   = (state_q != rsr_pkg::ST_LOAD);

    case (state_q)
      rsr_pkg::ST_LOAD: begin
        if (in_acc) begin
          case (req_type_i)
            rsr_pkg::REQ_START: begin
              ctrl.ins = open_q;
              if (count_q == CW'(N)) begin
                ovf_d  = 1'b1;
                open_d = 1'b0;
              end else begin
                hold_d.name_high = name_norm[79:64];
                hold_d.name_low  = name_norm[63:0];
                hold_d.total     = '0;
                hold_d.id        = count_q + CW'(1);
                count_d          = count_q + CW'(1);
                open_d           = 1'b1;
              end
            end
            rsr_pkg::REQ_FEE: begin
              if (open_q) hold_d.total = fee_sum[TW] ? {TW{1'b1}} : fee_sum[TW-1:0];
            end
            rsr_pkg::REQ_FINISH: begin
              ctrl.ins = open_q;
              open_d   = 1'b0;
              idx_d    = '0;
              state_d  = rsr_pkg::ST_DRAIN;
            end
            default: ;
          endcase
        end
      end
      rsr_pkg::ST_DRAIN: begin
        if (drain_step) begin
          out_valid_d = 1'b1;
          o_ovf_d     = ovf_q;
          if (count_q == '0) begin
            o_rank_d = '0;
            o_rec_d  = '0;
            o_has_d  = 1'b0;
            o_last_d = 1'b1;
          end else begin
            ctrl.shift   = 1'b1;
            o_rank_d     = 6'(cur_rank);
            o_rec_d      = cell_rec[0];
            o_has_d      = 1'b1;
            o_last_d     = (idx_q + CW'(1) == count_q);
            rank_d       = cur_rank;
            prev_total_d = cell_rec[0].total;
            idx_d        = idx_q + CW'(1);
          end
          if (count_q == '0 || idx_q + CW'(1) == count_q) begin
            state_d = rsr_pkg::ST_LOAD;
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = rsr_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsr_pkg::ST_LOAD;
      open_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q       <= hold_d;
    rank_q       <= rank_d;
    prev_total_q <= prev_total_d;
    o_rank_q     <= o_rank_d;
    o_rec_q      <= o_rec_d;
    o_has_q      <= o_has_d;
    o_ovf_q      <= o_ovf_d;
    o_last_q     <= o_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign rank_o          = o_rank_q;
  assign record_id_o     = 6'(o_rec_q.id);
  assign out_name_high_o = o_rec_q.name_high;
  assign out_name_low_o  = o_rec_q.name_low;
  assign total_out_o     = o_rec_q.total;
  assign has_record_o    = o_has_q;
  assign overflowed_o    = o_ovf_q;
  assign last_o          = o_last_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N)) else $error("record count beyond capacity");
  a_open_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> count_q != '0) else $error("open record without count");
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_step && count_q != '0) |-> cell_valid[0])
    else $error("drain reads empty head cell");
  a_real_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_record_o) |-> rank_o != '0) else $error("zero rank on record");
  a_drain_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_step && o_last_d) |=> state_q == rsr_pkg::ST_LOAD && count_q == '0)
    else $error("run did not close after last beat");

endmodule

// ----- verif/tb_record_sort_and_rank_unit.sv -----
module tb_record_sort_and_rank_unit;

  typedef struct packed {
    logic [5:0]  rank;
    logic [5:0]  id;
    logic [15:0] nh;
    logic [63:0] nl;
    logic [23:0] total;
    logic        has;
    logic        ovf;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = rsr_pkg::REQ_FEE;
  logic [15:0] name_high_i = '0;
  logic [63:0] name_low_i = '0;
  logic [15:0] fee_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  rank_o;
  logic [5:0]  record_id_o;
  logic [15:0] out_name_high_o;
  logic [63:0] out_name_low_o;
  logic [23:0] total_out_o;
  logic        has_record_o;
  logic        overflowed_o;
  logic        last_o;

  record_sort_and_rank_unit uut (.*);

  always #1 clk_i = ~clk_i;

  // shadow of the record store
  logic [79:0] shadow_name [rsr_pkg::MAX_RECORDS];
  logic [23:0] shadow_total [rsr_pkg::MAX_RECORDS];
  logic [5:0]  shadow_id [rsr_pkg::MAX_RECORDS];
  int          shadow_count = 0;
  bit          shadow_ovf = 0;
  bit          shadow_open = 0;

  result_t ranked_q [$];
  int      error_count = 0;
  bit      send_gaps = 1;
  bit      recv_gaps = 1;
  bit      recv_hold = 0;

  function automatic logic [79:0] cut_name(logic [79:0] raw);
    logic [79:0] r;
    bit          ended;
    r = raw;
    ended = 0;
    for (int i = 0; i < 10; i++) begin
      if (i >= rsr_pkg::NAME_CHARS || raw[79-8*i -: 8] == 8'd0) ended = 1;
      if (ended) r[79-8*i -: 8] = 8'd0;
    end
    return r;
  endfunction

  function automatic bit ranks_ahead(int a, int b);
    if (shadow_total[a] != shadow_total[b]) return shadow_total[a] > shadow_total[b];
    if (shadow_name[a] != shadow_name[b]) return shadow_name[a] < shadow_name[b];
    return shadow_id[a] < shadow_id[b];
  endfunction

  // update the shadow store and queue results for one accepted beat
  task automatic predict_beat(logic [1:0] req, logic [79:0] name, logic [15:0] fee);
    int        order [rsr_pkg::MAX_RECORDS];
    int        j;
    int        cur;
    int        rk;
    logic [24:0] sum;
    result_t   r;
    case (req)
      rsr_pkg::REQ_START: begin
        if (shadow_count >= rsr_pkg::MAX_RECORDS) begin
          shadow_ovf = 1;
          shadow_open = 0;
        end else begin
          shadow_name[shadow_count] = cut_name(name);
          shadow_total[shadow_count] = '0;
          shadow_id[shadow_count] = 6'(shadow_count + 1);
          shadow_count++;
          shadow_open = 1;
        end
      end
      rsr_pkg::REQ_FEE: begin
        if (shadow_open && shadow_count > 0) begin
          sum = shadow_total[shadow_count-1] + fee;
          shadow_total[shadow_count-1] = sum > 25'hFFFFFF ? 24'hFFFFFF : sum[23:0];
        end
      end
      rsr_pkg::REQ_FINISH: begin
        if (shadow_count == 0) begin
          r = '0;
          r.ovf = shadow_ovf;
          r.last = 1'b1;
          ranked_q.push_back(r);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            cur = i;
            j = i;
            while (j > 0 && ranks_ahead(cur, order[j-1])) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = cur;
          end
          rk = 1;
          for (int i = 0; i < shadow_count; i++) begin
            if (i > 0 && shadow_total[order[i]] != shadow_total[order[i-1]]) rk = i + 1;
            r.rank = 6'(rk);
            r.id = shadow_id[order[i]];
            r.nh = shadow_name[order[i]][79:64];
            r.nl = shadow_name[order[i]][63:0];
            r.total = shadow_total[order[i]];
            r.has = 1'b1;
            r.ovf = shadow_ovf;
            r.last = (i + 1 == shadow_count);
            ranked_q.push_back(r);
          end
        end
        shadow_count = 0;
        shadow_ovf = 0;
        shadow_open = 0;
      end
      default: ;
    endcase
  endtask

  // drive one beat, hold until accepted
  task automatic send_beat(logic [1:0] req, logic [79:0] name, logic [15:0] fee);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    name_high_i <= name[79:64];
    name_low_i <= name[63:0];
    fee_i <= fee;
    do @(posedge clk_i); while (in_stall_o);
    predict_beat(req, name, fee);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ranked_q.size() != 0) @(posedge clk_i);
  endtask

  // random printable name with random cut point, sometimes raw bits
  function automatic logic [79:0] rand_name();
    logic [79:0] n;
    int          len;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom, 16'($urandom)};
    len = $urandom_range(0, 10);
    n = '0;
    for (int i = 0; i < len; i++) n[79-8*i -: 8] = 8'($urandom_range(65, 70));
    return n;
  endfunction

  function automatic logic [15:0] rand_fee();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got;
    if (out_valid_o && !out_stall_i) begin
      got = {rank_o, record_id_o, out_name_high_o, out_name_low_o, total_out_o,
             has_record_o, overflowed_o, last_o};
      if (ranked_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        exp_r = ranked_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch exp rank %0d id %0d name %h_%h total %0d has %b ovf %b last %b",
                   $time, exp_r.rank, exp_r.id, exp_r.nh, exp_r.nl, exp_r.total,
                   exp_r.has, exp_r.ovf, exp_r.last);
          $display("%0t:          got rank %0d id %0d name %h_%h total %0d has %b ovf %b last %b",
                   $time, got.rank, got.id, got.nh, got.nl, got.total,
                   got.has, got.ovf, got.last);
          error_count++;
        end
      end
    end
  end

  // receiver stalls: random bursts, or a long counted hold
  initial begin
    int hold_cnt;
    forever begin
      @(posedge clk_i);
      if (recv_hold) begin
        out_stall_i <= 1'b1;
        hold_cnt = 0;
        while (hold_cnt < 120) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        out_stall_i <= 1'b0;
        recv_hold = 0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    send_beat(rsr_pkg::REQ_FINISH, '0, '0);            // empty finish
    send_beat(rsr_pkg::REQ_FEE, '0, 16'd5);            // fee with nothing open
    send_beat(2'd3, {80{1'b1}}, 16'hFFFF);             // unused code
    send_beat(rsr_pkg::REQ_START, {80{1'b1}}, '0);
    for (int i = 0; i < 260; i++) send_beat(rsr_pkg::REQ_FEE, '0, 16'hFFFF); // saturate
    send_beat(rsr_pkg::REQ_START, 80'h4100_0042_0000_0000_0000, 16'd1); // zero cut
    send_beat(rsr_pkg::REQ_FEE, '0, 16'd7);
    send_beat(rsr_pkg::REQ_START, 80'h4142_4344_4546_4748_494A, '0);
    send_beat(rsr_pkg::REQ_FEE, '0, 16'd7);
    send_beat(rsr_pkg::REQ_START, 80'h4142_4344_4546_4748_494A, '0); // same name, id tie
    send_beat(rsr_pkg::REQ_FEE, '0, 16'd7);
    send_beat(rsr_pkg::REQ_START, '0, '0);
    send_beat(rsr_pkg::REQ_FINISH, '0, '0);
    send_beat(rsr_pkg::REQ_FEE, '0, 16'd9);            // after finish: ignored
    send_beat(rsr_pkg::REQ_FINISH, '0, '0);
    go_idle();
  endtask

  // fill past capacity, then drain while the receiver holds off
  task automatic test_overflow();
    for (int i = 0; i < rsr_pkg::MAX_RECORDS + 2; i++) begin
      send_beat(rsr_pkg::REQ_START, rand_name(), '0);
      send_beat(rsr_pkg::REQ_FEE, '0, 16'($urandom_range(0, 3)));
    end
    send_beat(rsr_pkg::REQ_FEE, '0, 16'd50);           // after overflowing start
    recv_hold = 1;
    send_beat(rsr_pkg::REQ_FINISH, '0, '0);
    send_beat(rsr_pkg::REQ_START, rand_name(), '0);
    send_beat(rsr_pkg::REQ_FEE, '0, rand_fee());
    send_beat(rsr_pkg::REQ_FINISH, '0, '0);
    send_beat(rsr_pkg::REQ_START, rand_name(), '0);
    send_beat(rsr_pkg::REQ_START, rand_name(), '0);
    send_beat(rsr_pkg::REQ_FINISH, '0, '0);
    go_idle();
  endtask

  task automatic test_random(int n_items);
    int sent;
    int recs;
    sent = 0;
    while (sent < n_items) begin
      recs = $urandom_range(0, 7) == 0 ? $urandom_range(20, 34) : $urandom_range(0, 6);
      for (int r = 0; r < recs && sent < n_items; r++) begin
        send_beat(rsr_pkg::REQ_START, rand_name(), rand_fee());
        repeat ($urandom_range(0, 3)) begin
          send_beat(rsr_pkg::REQ_FEE, {$urandom, $urandom, 16'($urandom)}, rand_fee());
          sent++;
        end
        if ($urandom_range(0, 15) == 0) begin
          send_beat(2'($urandom_range(1, 3)), rand_name(), rand_fee());
          sent++;
        end
        sent++;
      end
      send_beat(rsr_pkg::REQ_FINISH, {$urandom, $urandom, 16'($urandom)}, rand_fee());
      sent++;
      if (send_gaps && $urandom_range(0, 9) == 0) go_idle();
    end
    go_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(45);
    send_gaps = 0;
    recv_gaps = 0;
    test_random(25);
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && ranked_q.size() == 0)
      $display("record_sort_and_rank_unit verification clean");
    else
      $display("record_sort_and_rank_unit verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("record_sort_and_rank_unit verification failed");
    $finish;
  end

endmodule
